// ===== rtl/adq_pkg.sv =====
// ---------------------------------------------------------------------------
// adq_pkg
// shared types and constants for the array double-ended queue
// ---------------------------------------------------------------------------
package adq_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SIZE_W = 7;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   // common width for comparing the size register against slot counts
   localparam int CMP_W = (SIZE_W > IDX_W + 1) ? SIZE_W : IDX_W + 1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   typedef enum logic [1:0] {
      CMD_INS_FRONT = 2'd0,
      CMD_INS_REAR  = 2'd1,
      CMD_DEL_FRONT = 2'd2,
      CMD_DEL_REAR  = 2'd3
   } cmd_type;

   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = STATUS_W'(2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_read;
   } ctrl_type;

   typedef struct packed {
      logic read_go;
   } stat_type;

endpackage

// ===== rtl/adq_ctrl.sv =====
// ---------------------------------------------------------------------------
// adq_ctrl
// sequencer: takes one word, runs it through the datapath, holds the response
// ---------------------------------------------------------------------------
module adq_ctrl
   import adq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output ctrl_type ctrl,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.read_go ? S_READ : S_RESP;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      ctrl = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            ctrl.capture = req_valid;
         end
         S_EXEC: begin
            ctrl.execute = 1'b1;
         end
         S_READ: begin
            ctrl.load_read = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/adq_datapath.sv =====
// ---------------------------------------------------------------------------
// adq_datapath
// slot memory, front and rear pointers, size register and response registers
// ---------------------------------------------------------------------------
module adq_datapath
   import adq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_type                   ctrl,
   output stat_type                   stat,
   input  logic [1:0]                 req_cmd,
   input  logic signed [DATA_W-1:0]   req_value_in,
   input  logic                       csr_write_enable,
   input  logic [SIZE_W-1:0]          csr_write_data,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_value_out
);

   logic [DATA_W-1:0]   slots [DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;

   cmd_type             cmd_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [IDX_W-1:0]    rear_ff, rear_in;
   logic                empty_ff, empty_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   out_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [IDX_W-1:0]    rd_addr;
   logic                read_go;
   logic [CMP_W-1:0]    size_ext;
   logic [CMP_W-1:0]    usable;
   logic [CMP_W-1:0]    rear_next_ext;

   // a size of zero acts as one, anything past the array acts as the array
   assign size_ext = CMP_W'(size_ff);
   assign usable = (size_ff == '0) ? CMP_W'(1)
                 : (size_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : size_ext;
   assign rear_next_ext = CMP_W'(rear_ff) + CMP_W'(1);

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      empty_in  = empty_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_addr   = front_ff;
      read_go   = 1'b0;
      case (cmd_ff)
         CMD_INS_FRONT: begin
            if (empty_ff) begin
               empty_in = 1'b0;
               front_in = '0;
               rear_in  = '0;
               wr_en    = 1'b1;
            end else if (front_ff == '0) begin
               status_in = ST_OVERFLOW;
            end else begin
               front_in = front_ff - IDX_W'(1);
               wr_en    = 1'b1;
               wr_addr  = front_ff - IDX_W'(1);
            end
         end
         CMD_INS_REAR: begin
            if (empty_ff) begin
               empty_in = 1'b0;
               front_in = '0;
               rear_in  = '0;
               wr_en    = 1'b1;
            end else if (rear_next_ext >= usable) begin
               status_in = ST_OVERFLOW;
            end else begin
               rear_in = rear_ff + IDX_W'(1);
               wr_en   = 1'b1;
               wr_addr = rear_ff + IDX_W'(1);
            end
         end
         CMD_DEL_FRONT: begin
            if (empty_ff) begin
               status_in = ST_UNDERFLOW;
            end else begin
               read_go = 1'b1;
               rd_addr = front_ff;
               if (front_ff == rear_ff) begin
                  empty_in = 1'b1;
                  front_in = '0;
                  rear_in  = '0;
               end else begin
                  front_in = front_ff + IDX_W'(1);
               end
            end
         end
         CMD_DEL_REAR: begin
            if (empty_ff) begin
               status_in = ST_UNDERFLOW;
            end else begin
               read_go = 1'b1;
               rd_addr = rear_ff;
               if (front_ff == rear_ff) begin
                  empty_in = 1'b1;
                  front_in = '0;
                  rear_in  = '0;
               end else begin
                  rear_in = rear_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign stat.read_go = ctrl.execute & read_go;

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.execute && wr_en) begin
         slots[wr_addr] <= value_ff;
      end
      rd_data_ff <= slots[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
         size_ff  <= SIZE_RESET;
      end else begin
         if (ctrl.execute) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            empty_ff <= empty_in;
         end
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= cmd_type'(req_cmd);
         value_ff <= req_value_in;
      end
      if (ctrl.execute) begin
         status_ff <= status_in;
         out_ff    <= '0;
      end else if (ctrl.load_read) begin
         out_ff <= rd_data_ff;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value_out = out_ff;

endmodule

// ===== rtl/array_double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// array_double_ended_queue
// non-circular array deque with front and rear insert and delete
// ---------------------------------------------------------------------------
// Each word carries a command (insert front, insert rear, delete front, delete
// rear) and gets exactly one response word with a status (ok, overflow,
// underflow) and the removed value on a successful delete. Words are handled
// one at a time. The response to an insert or a failed command is offered
// in the state that follows the execute state. A successful delete also
// passes through a read state, because the single slot memory has a
// registered read. req_stall stays high until the response is taken.
// An insert into an empty deque lands in slot 0, so front inserts overflow
// unless front deletes have opened room. csr_write_data sets how many slots
// rear inserts may use (0 acts as 1, values above the depth act as the depth);
// write it only while idle. Slot contents have no reset.
module array_double_ended_queue
   import adq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_value_out,
   input  logic                     csr_write_enable,
   input  logic [SIZE_W-1:0]        csr_write_data
);

   ctrl_type ctrl;
   stat_type stat;

   adq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   adq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_value_in     (req_value_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out)
   );

endmodule
